/* hdl/stepcal_pkg.sv */
// ----------------------------------------------------------------------------
// stepcal_pkg
// types, codes and defaults shared by the stepper home calibrator
// ----------------------------------------------------------------------------
package stepcal_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int TIMER_BITS_DEF = 20;

	localparam int TIMEOUT_W = 20;
	localparam int PERIOD_W  = 8;
	localparam int OUT_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(40 * 1000);
	localparam logic [PERIOD_W-1:0]  SETTLE_RST  = PERIOD_W'(100);
	localparam logic [PERIOD_W-1:0]  FAST_RST    = PERIOD_W'(1);
	localparam logic [PERIOD_W-1:0]  SLOW_RST    = PERIOD_W'(10);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT = 2'd0,
		CFG_SETTLE  = 2'd1,
		CFG_FAST    = 2'd2,
		CFG_SLOW    = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_SETTLE   = 3'd1,
		PH_ROTATE   = 3'd2,
		PH_GAP_OUT  = 3'd3,
		PH_GAP_BACK = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_CCW  = 2'd1,
		STEP_CW   = 2'd2
	} step_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [PERIOD_W-1:0]  settle_ticks;
		logic [PERIOD_W-1:0]  fast_period;
		logic [PERIOD_W-1:0]  slow_period;
	} cfg_t;

	typedef struct packed {
		logic [OUT_W-1:0]        home_gap;
		logic [OUT_W-1:0]        steps_per_rotation;
		logic                    success;
		logic                    done_res;
		logic                    busy_res;
		logic                    motor_power;
		step_t                   step_pulse;
	} res_t;

endpackage

/* hdl/stepcal_cfg.sv */
// ----------------------------------------------------------------------------
// stepcal_cfg
// configuration registers written through the register write channel
// ----------------------------------------------------------------------------
module stepcal_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [stepcal_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stepcal_pkg::TIMEOUT_W-1:0]  cfg_data,
	output stepcal_pkg::cfg_t                  cfg
);

	stepcal_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= stepcal_pkg::TIMEOUT_RST;
			cfg_q.settle_ticks  <= stepcal_pkg::SETTLE_RST;
			cfg_q.fast_period   <= stepcal_pkg::FAST_RST;
			cfg_q.slow_period   <= stepcal_pkg::SLOW_RST;
		end else if (cfg_valid) begin
			case (stepcal_pkg::cfg_idx_t'(cfg_index))
				stepcal_pkg::CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data;
				stepcal_pkg::CFG_SETTLE: begin
					cfg_q.settle_ticks <= cfg_data[stepcal_pkg::PERIOD_W-1:0];
				end
				stepcal_pkg::CFG_FAST: begin
					cfg_q.fast_period <= cfg_data[stepcal_pkg::PERIOD_W-1:0];
				end
				stepcal_pkg::CFG_SLOW: begin
					cfg_q.slow_period <= cfg_data[stepcal_pkg::PERIOD_W-1:0];
				end
				default: ;
			endcase
		end
	end

endmodule

/* hdl/stepcal_fsm.sv */
// ----------------------------------------------------------------------------
// stepcal_fsm
// homing sequence state, counters and per-tick result logic
// ----------------------------------------------------------------------------
module stepcal_fsm #(
	parameter int COUNT_BITS = stepcal_pkg::COUNT_BITS_DEF,
	parameter int TIMER_BITS = stepcal_pkg::TIMER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic                cmd,
	input  logic                home,
	input  stepcal_pkg::cfg_t   cfg,
	output stepcal_pkg::res_t   res
);

	localparam int PW    = stepcal_pkg::PERIOD_W;
	localparam int CMP_W = (TIMER_BITS > stepcal_pkg::TIMEOUT_W) ?
		TIMER_BITS : stepcal_pkg::TIMEOUT_W;
	localparam int SAT_W = COUNT_BITS + 17;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic signed [COUNT_BITS-1:0] GAP_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] GAP_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
	localparam logic [SAT_W-1:0] ROT_SAT = SAT_W'({stepcal_pkg::OUT_W{1'b1}});
	localparam logic signed [SAT_W-1:0] G_HI = SAT_W'(32'sd32767);
	localparam logic signed [SAT_W-1:0] G_LO = SAT_W'(-32'sd32768);

	stepcal_pkg::phase_t             phase_q, phase_d;
	logic                            prev_q, prev_d;
	logic                            first_q, first_d;
	logic [TIMER_BITS-1:0]           elapsed_q, elapsed_d;
	logic [PW-1:0]                   period_q, period_d;
	logic [COUNT_BITS-1:0]           steps_q, steps_d;
	logic signed [COUNT_BITS-1:0]    gap_q, gap_d;
	logic [COUNT_BITS-1:0]           rot_q, rot_d;
	logic signed [COUNT_BITS-1:0]    gres_q, gres_d;

	stepcal_pkg::step_t              step;
	logic                            done;
	logic                            ok;
	logic                            rise;
	logic                            fall;
	logic [SAT_W-1:0]                rot_w;
	logic signed [SAT_W-1:0]         gap_w;

	function automatic logic [PW-1:0] reload(input logic [PW-1:0] period);
		reload = (period == '0) ? '0 : period - 1'b1;
	endfunction

	assign rise = !prev_q && home;
	assign fall = prev_q && !home;

	always_comb begin
		phase_d   = phase_q;
		prev_d    = prev_q;
		first_d   = first_q;
		elapsed_d = elapsed_q;
		period_d  = period_q;
		steps_d   = steps_q;
		gap_d     = gap_q;
		rot_d     = rot_q;
		gres_d    = gres_q;
		step      = stepcal_pkg::STEP_NONE;
		done      = 1'b0;
		ok        = 1'b0;

		case (phase_q)
			stepcal_pkg::PH_IDLE: begin
				if (cmd) begin
					prev_d    = home;
					first_d   = 1'b0;
					steps_d   = '0;
					gap_d     = '0;
					phase_d   = stepcal_pkg::PH_SETTLE;
					elapsed_d = '0;
					period_d  = '0;
				end
			end
			stepcal_pkg::PH_SETTLE: begin
				if (period_q >= cfg.settle_ticks) begin
					phase_d   = stepcal_pkg::PH_ROTATE;
					elapsed_d = '0;
					period_d  = '0;
				end else begin
					period_d = period_q + 1'b1;
				end
			end
			default: begin
				if (CMP_W'(elapsed_q) >= CMP_W'(cfg.timeout_ticks)) begin
					done = 1'b1;
				end else begin
					if (elapsed_q != TIMER_MAX) elapsed_d = elapsed_q + 1'b1;
					if (period_q != '0) begin
						period_d = period_q - 1'b1;
					end else if (phase_q == stepcal_pkg::PH_ROTATE) begin
						period_d = reload(cfg.fast_period);
						if (rise && first_q) begin
							rot_d     = steps_q;
							gap_d     = '0;
							phase_d   = stepcal_pkg::PH_GAP_OUT;
							elapsed_d = '0;
							period_d  = '0;
						end else begin
							if (rise) begin
								first_d   = 1'b1;
								elapsed_d = '0;
							end
							prev_d = home;
							if (rise) begin
								steps_d = COUNT_BITS'(1);
							end else if (steps_q != COUNT_MAX) begin
								steps_d = steps_q + 1'b1;
							end
							step = stepcal_pkg::STEP_CCW;
						end
					end else if (phase_q == stepcal_pkg::PH_GAP_OUT) begin
						period_d = reload(cfg.slow_period);
						if (fall) begin
							phase_d   = stepcal_pkg::PH_GAP_BACK;
							elapsed_d = '0;
							period_d  = '0;
						end else begin
							if (gap_q != GAP_MAX) gap_d = gap_q + COUNT_BITS'(1);
							prev_d = home;
							step   = stepcal_pkg::STEP_CCW;
						end
					end else begin
						period_d = reload(cfg.slow_period);
						if (rise) begin
							gres_d = gap_q;
							done   = 1'b1;
							ok     = 1'b1;
						end else begin
							if (gap_q != GAP_MIN) gap_d = gap_q - COUNT_BITS'(1);
							prev_d = home;
							step   = stepcal_pkg::STEP_CW;
						end
					end
				end
			end
		endcase

		if (done) begin
			phase_d   = stepcal_pkg::PH_IDLE;
			elapsed_d = '0;
			period_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= stepcal_pkg::PH_IDLE;
			prev_q    <= 1'b0;
			first_q   <= 1'b0;
			elapsed_q <= '0;
			period_q  <= '0;
			steps_q   <= '0;
			gap_q     <= '0;
			rot_q     <= '0;
			gres_q    <= '0;
		end else if (tick) begin
			phase_q   <= phase_d;
			prev_q    <= prev_d;
			first_q   <= first_d;
			elapsed_q <= elapsed_d;
			period_q  <= period_d;
			steps_q   <= steps_d;
			gap_q     <= gap_d;
			rot_q     <= rot_d;
			gres_q    <= gres_d;
		end
	end

	// saturate results into the 16 bit output fields
	assign rot_w = SAT_W'(rot_d);
	assign gap_w = SAT_W'(gres_d);

	always_comb begin
		res.step_pulse  = step;
		res.motor_power = (phase_d != stepcal_pkg::PH_IDLE);
		res.busy_res    = (phase_d != stepcal_pkg::PH_IDLE);
		res.done_res    = done;
		res.success     = ok;
		res.steps_per_rotation = (rot_w > ROT_SAT) ?
			{stepcal_pkg::OUT_W{1'b1}} : rot_w[stepcal_pkg::OUT_W-1:0];
		if (gap_w > G_HI) begin
			res.home_gap = G_HI[stepcal_pkg::OUT_W-1:0];
		end else if (gap_w < G_LO) begin
			res.home_gap = G_LO[stepcal_pkg::OUT_W-1:0];
		end else begin
			res.home_gap = gap_w[stepcal_pkg::OUT_W-1:0];
		end
	end

endmodule

/* hdl/stepper_home_calibrator_core.sv */
// ----------------------------------------------------------------------------
// stepper_home_calibrator_core
// stepper homing calibration, one timer tick in and one status item out
//
//   channel   direction   signals                             item
//   s_*       in          tvalid tready tdata tuser           one timer tick
//   m_*       out         tvalid tready tdata tlast           tick status
//   cfg_*     in          valid ready index data              register write
//
// one item per clock unless m_tready stalls: input register, one pass of sequence
// logic, result register; the result register frees when empty or m_tready is high
// the input register takes a new item when empty or when the result register frees
// reset clears the sequence to idle and loads register defaults
// cfg_ready is always high
// ----------------------------------------------------------------------------
module stepper_home_calibrator_core #(
	parameter int COUNT_BITS = stepcal_pkg::COUNT_BITS_DEF,
	parameter int TIMER_BITS = stepcal_pkg::TIMER_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // home_sensor
	input  logic                               s_tuser,   // cmd
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// step_pulse, motor_power, busy_res, success, steps_per_rotation, home_gap
	output logic [39:0]                        m_tdata,
	output logic                               m_tlast,   // done_res
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [stepcal_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stepcal_pkg::TIMEOUT_W-1:0]  cfg_data
);

	stepcal_pkg::cfg_t  cfg;
	stepcal_pkg::res_t  res;
	stepcal_pkg::res_t  res_s2;
	logic               valid_s1;
	logic               cmd_s1;
	logic               home_s1;
	logic               valid_s2;
	logic               adv;
	logic               tick;

	assign adv      = !valid_s2 || m_tready;
	assign tick     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			home_s1 <= s_tdata[0];
		end
		if (tick) res_s2 <= res;
	end

	stepcal_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	stepcal_fsm #(
		.COUNT_BITS (COUNT_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.cmd    (cmd_s1),
		.home   (home_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tlast  = res_s2.done_res;
	assign m_tdata  = {3'b000, res_s2.home_gap, res_s2.steps_per_rotation,
		res_s2.success, res_s2.busy_res, res_s2.motor_power, res_s2.step_pulse};

endmodule

/* hdl/stepcal_checker.sv */
// ----------------------------------------------------------------------------
// stepcal_checker
// port level checks on the calibrator output stream
// ----------------------------------------------------------------------------
module stepcal_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [7:0]                         s_tdata,
	input logic                               s_tuser,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [39:0]                        m_tdata,
	input logic                               m_tlast,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic [stepcal_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [stepcal_pkg::TIMEOUT_W-1:0]  cfg_data
);

	// stalled output item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// ending tick drops power and busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[2] && !m_tdata[3])
		else $error("done with power still on");

	// success only on the ending tick
	a_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tlast)
		else $error("success without done");

	// a step is only issued while powered
	a_step_power: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != 2'd0) |-> m_tdata[2] && m_tdata[3] && !m_tlast)
		else $error("step while unpowered");

endmodule

bind stepper_home_calibrator_core stepcal_checker u_stepcal_checker (.*);
